### sv/hbss_pkg.sv
// Shared types and constants for the H-bridge speed sweep sequencer.
package hbss_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_DEAD_TIME  = 3'd0;
   localparam logic [2:0] REG_PULSE_ON   = 3'd1;
   localparam logic [2:0] REG_SLOW_OFF   = 3'd2;
   localparam logic [2:0] REG_MEDIUM_OFF = 3'd3;
   localparam logic [2:0] REG_FAST_OFF   = 3'd4;
   localparam logic [2:0] REG_PULSES     = 3'd5;
   localparam logic [2:0] REG_REVERSALS  = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register reset values.
   localparam logic [7:0]  RST_DEAD_TIME  = 8'd5;
   localparam logic [7:0]  RST_PULSE_ON   = 8'd1;
   localparam logic [7:0]  RST_SLOW_OFF   = 8'd20;
   localparam logic [7:0]  RST_MEDIUM_OFF = 8'd10;
   localparam logic [7:0]  RST_FAST_OFF   = 8'd1;
   localparam logic [15:0] RST_PULSES     = 16'd10000;
   localparam logic [7:0]  RST_REVERSALS  = 8'd5;

   // Sequencer phases.
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_DEAD  = 2'd1;
   localparam logic [1:0] PH_ON    = 2'd2;
   localparam logic [1:0] PH_OFF   = 2'd3;

   // Speed codes.
   localparam logic [1:0] SPEED_SLOW   = 2'd0;
   localparam logic [1:0] SPEED_MEDIUM = 2'd1;
   localparam logic [1:0] SPEED_FAST   = 2'd2;

   typedef struct packed {
      logic [7:0]  dead_time_ticks;
      logic [7:0]  pulse_on_ticks;
      logic [7:0]  slow_off_ticks;
      logic [7:0]  medium_off_ticks;
      logic [7:0]  fast_off_ticks;
      logic [15:0] pulses_per_direction;
      logic [7:0]  reversals_per_speed;
   } cfg_type;

   // Levels driven during the coming tick.
   typedef struct packed {
      logic       heading_left;
      logic [1:0] speed_level;
      logic       left_high_gate;
      logic       left_low_gate;
      logic       right_low_gate;
      logic       right_high_gate;
   } gates_type;

   function automatic logic [7:0] at_least_one8(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

endpackage

### sv/h_bridge_speed_sweep_sequencer.sv
// Top level of the H-bridge speed sweep sequencer: handshake and result register.
//
//  channel  direction  tdata bits (low to high)
//  req_     in         [0] advance, [7:1] zero
//  rsp_     out        [0] right_high_gate, [1] right_low_gate, [2] left_low_gate,
//                      [3] left_high_gate, [5:4] speed_level, [6] heading_left, [7] zero
//  csr_     in         write enable, register index, write data
//
// Each request transaction is one tick. It is taken in the cycle it is offered
// as long as the result register is empty or being emptied in that cycle, so
// a tick can be accepted every clock cycle. The state update and the gate
// levels it produces are computed in one pass and captured in the result
// register, which presents them in the cycle after acceptance. Reset puts both
// low-side gates on, both high-side gates off and all counters at zero, and
// restores the register defaults. While a result waits in the register and
// the result side stalls, req_tready stays low and the sequencer state holds.
module h_bridge_speed_sweep_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [0] advance
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // rh, rl, ll, lh, speed[1:0], heading
   input  logic                             csr_we,
   input  logic [hbss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hbss_pkg::*;

   cfg_type   cfg;
   gates_type gates_next;
   logic      accept;
   logic      rsp_valid_ff, rsp_valid_in;
   gates_type rsp_data_ff;

   hbss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer moves only when a tick transaction is accepted.
   hbss_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (accept),
      .advance    (req_tdata[0]),
      .gates_next (gates_next)
   );

   // The result register may refill in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= gates_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // A bridge leg never has its high and low gates on together.
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.right_high_gate && rsp_data_ff.right_low_gate) &&
                       !(rsp_data_ff.left_high_gate && rsp_data_ff.left_low_gate))
      else $error("high and low gate of one leg both on");

   // At most one high-side gate is driven at a time.
   a_one_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.right_high_gate && rsp_data_ff.left_high_gate))
      else $error("both high-side gates on");

   // A stalled result blocks new ticks so none is lost.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("tick taken while result stalled");

endmodule

### sv/hbss_csr.sv
// Configuration register bank of the H-bridge speed sweep sequencer.
module hbss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hbss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output hbss_pkg::cfg_type                cfg
);
   import hbss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DEAD_TIME:  cfg_in.dead_time_ticks      = csr_wdata[7:0];
            REG_PULSE_ON:   cfg_in.pulse_on_ticks       = csr_wdata[7:0];
            REG_SLOW_OFF:   cfg_in.slow_off_ticks       = csr_wdata[7:0];
            REG_MEDIUM_OFF: cfg_in.medium_off_ticks     = csr_wdata[7:0];
            REG_FAST_OFF:   cfg_in.fast_off_ticks       = csr_wdata[7:0];
            REG_PULSES:     cfg_in.pulses_per_direction = csr_wdata[15:0];
            REG_REVERSALS:  cfg_in.reversals_per_speed  = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_time_ticks      <= RST_DEAD_TIME;
         cfg_ff.pulse_on_ticks       <= RST_PULSE_ON;
         cfg_ff.slow_off_ticks       <= RST_SLOW_OFF;
         cfg_ff.medium_off_ticks     <= RST_MEDIUM_OFF;
         cfg_ff.fast_off_ticks       <= RST_FAST_OFF;
         cfg_ff.pulses_per_direction <= RST_PULSES;
         cfg_ff.reversals_per_speed  <= RST_REVERSALS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/hbss_core.sv
// Phase, tick and count state of the sequencer and its one-tick update.
module hbss_core (
   input  logic                clock,
   input  logic                reset,
   input  hbss_pkg::cfg_type   cfg,
   input  logic                step,
   input  logic                advance,
   output hbss_pkg::gates_type gates_next
);
   import hbss_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  ticks_ff, ticks_in;
   logic [15:0] pulses_ff, pulses_in;
   logic [7:0]  reversals_ff, reversals_in;
   logic [1:0]  speed_ff, speed_in;
   logic        left_ff, left_in;

   always_comb begin
      logic [7:0]  tick_dec;
      logic [7:0]  off_len;
      logic [15:0] pulse_inc;
      logic [15:0] pulse_limit;
      logic [7:0]  rev_inc;
      logic        to_dead;

      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      pulses_in    = pulses_ff;
      reversals_in = reversals_ff;
      speed_in     = speed_ff;
      left_in      = left_ff;
      to_dead      = 1'b0;

      tick_dec    = (ticks_ff != 8'd0) ? ticks_ff - 8'd1 : 8'd0;
      pulse_inc   = pulses_ff + 16'd1;
      pulse_limit = (cfg.pulses_per_direction == 16'd0) ? 16'd1 : cfg.pulses_per_direction;
      rev_inc     = reversals_ff + 8'd1;

      case (speed_ff)
         SPEED_SLOW:   off_len = at_least_one8(cfg.slow_off_ticks);
         SPEED_MEDIUM: off_len = at_least_one8(cfg.medium_off_ticks);
         default:      off_len = at_least_one8(cfg.fast_off_ticks);
      endcase

      if (advance) begin
         if (phase_ff == PH_START) begin
            to_dead = 1'b1;
         end else begin
            ticks_in = tick_dec;
            if (tick_dec == 8'd0) begin
               case (phase_ff)
                  PH_DEAD: begin
                     phase_in = PH_ON;
                     ticks_in = at_least_one8(cfg.pulse_on_ticks);
                  end
                  PH_ON: begin
                     phase_in = PH_OFF;
                     ticks_in = off_len;
                  end
                  default: begin
                     // End of one pulse: either the next pulse or a reversal.
                     if (pulse_inc < pulse_limit) begin
                        pulses_in = pulse_inc;
                        phase_in  = PH_ON;
                        ticks_in  = at_least_one8(cfg.pulse_on_ticks);
                     end else begin
                        pulses_in = 16'd0;
                        to_dead   = 1'b1;
                        if (!left_ff) begin
                           left_in = 1'b1;
                        end else begin
                           left_in      = 1'b0;
                           reversals_in = rev_inc;
                           if (rev_inc >= at_least_one8(cfg.reversals_per_speed)) begin
                              reversals_in = 8'd0;
                              speed_in = (speed_ff >= SPEED_FAST) ? SPEED_SLOW
                                                                  : speed_ff + 2'd1;
                           end
                        end
                     end
                  end
               endcase
            end
         end
      end

      // Low gates were just switched; a zero dead time goes straight to pulsing.
      if (to_dead) begin
         if (cfg.dead_time_ticks == 8'd0) begin
            phase_in = PH_ON;
            ticks_in = at_least_one8(cfg.pulse_on_ticks);
         end else begin
            phase_in = PH_DEAD;
            ticks_in = cfg.dead_time_ticks;
         end
      end

      gates_next.speed_level     = speed_in;
      gates_next.heading_left    = left_in;
      gates_next.right_low_gate  = (phase_in == PH_START) ? 1'b1 : !left_in;
      gates_next.left_low_gate   = (phase_in == PH_START) ? 1'b1 : left_in;
      gates_next.right_high_gate = (phase_in == PH_ON) && left_in;
      gates_next.left_high_gate  = (phase_in == PH_ON) && !left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         ticks_ff     <= 8'd0;
         pulses_ff    <= 16'd0;
         reversals_ff <= 8'd0;
         speed_ff     <= SPEED_SLOW;
         left_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         pulses_ff    <= pulses_in;
         reversals_ff <= reversals_in;
         speed_ff     <= speed_in;
         left_ff      <= left_in;
      end
   end

   // Every timed phase holds a nonzero tick count.
   a_ticks_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_START |-> ticks_ff != 8'd0)
      else $error("timed phase with zero ticks left");

   // Once the sweep has started it never goes back to the start phase.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_START |=> phase_ff != PH_START)
      else $error("sequencer returned to start phase");

   // Speed code stays within slow, medium and fast.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff == SPEED_SLOW || speed_ff == SPEED_MEDIUM || speed_ff == SPEED_FAST)
      else $error("speed code out of range");

endmodule
